@@ design/lsi_pkg.sv @@
// Shared types, constants and the saturator of the Lorenz integrator.
package lsi_pkg;

  localparam int STATE_W    = 32;
  localparam int FRAC_W     = 22;
  localparam int RHO_W      = 30;
  localparam int DT_W       = 32;
  localparam int CNT_W      = 32;
  localparam int OP_W       = 36;
  localparam int PROD_W     = 2 * OP_W;
  localparam int KS_W       = 35;
  localparam int EXT_W      = 80;
  localparam int DIVD_W     = 40;
  localparam int DIV_DIGIT  = 6;
  localparam int DIV_STEPS  = 7;
  localparam int DIV_SH_W   = DIV_DIGIT * DIV_STEPS;
  localparam int QUOT_W     = DIV_SH_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [STATE_W-1:0] ONE_Q  = STATE_W'(64'sd1 <<< FRAC_W);
  localparam logic signed [STATE_W-1:0] BETA_Q = STATE_W'(((64'sd16 <<< FRAC_W) + 3) / 6);
  localparam logic [RHO_W-1:0]          RHO_RST = RHO_W'(117440512);
  localparam logic [DT_W-1:0]           DT_RST  = DT_W'(42949673);

  localparam logic signed [EXT_W-1:0] SAT_HI = (EXT_W'(1) <<< (STATE_W - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RHO, CFG_DT, CFG_RK, CFG_SX, CFG_SY, CFG_SZ
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_EV0, PH_EV1, PH_EV2, PH_EV3, PH_ACC, PH_MVM, PH_MVA,
    PH_FM, PH_FDS, PH_FDW, PH_FA, PH_FIN
  } phase_e;

  typedef struct packed {
    logic                      clip;
    logic signed [STATE_W-1:0] val;
  } sat_t;

  // Clamp a wide signed value to the state range
  function automatic sat_t sat_state(input logic signed [EXT_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.clip = 1'b1;
      r.val  = STATE_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r.clip = 1'b1;
      r.val  = STATE_W'(SAT_LO);
    end else begin
      r.clip = 1'b0;
      r.val  = STATE_W'(v);
    end
    return r;
  endfunction

endpackage

@@ design/lsi_tick_if.sv @@
// Tick channel: one beat per reload or integration step.
interface lsi_tick_if;
  logic valid;
  logic ready;
  logic reload;
  modport source(output valid, output reload, input ready);
  modport sink(input valid, input reload, output ready);
endinterface

@@ design/lsi_result_if.sv @@
// Result channel: new state, step index and clip flag.
interface lsi_result_if import lsi_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [STATE_W-1:0] out_x;
  logic signed [STATE_W-1:0] out_y;
  logic signed [STATE_W-1:0] out_z;
  logic [CNT_W-1:0]          step_index;
  logic                      saturated;
  modport source(output valid, output out_x, output out_y, output out_z,
                 output step_index, output saturated, input ready);
  modport sink(input valid, input out_x, input out_y, input out_z,
               input step_index, input saturated, output ready);
endinterface

@@ design/lsi_cfg_if.sv @@
// Configuration write channel: register index and data.
interface lsi_cfg_if import lsi_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ design/lorenz_system_integrator_core.sv @@
// Reset: config registers and state return to their defaults, state is 1.0 each, count is zero.
// A result waits in its final phase until the output register is free, so a stalled output delays it.
// The block takes one tick at a time; the shared 36x36 multiplier sequences every product
// (three per derivative, one per dt term) and the final RK4 division by six is digit-serial.
// Ready rises at the edge that loads the result into the output register.
module lorenz_system_integrator_core import lsi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  lsi_cfg_if.sink      cfg_i,
  lsi_tick_if.sink     in_i,
  lsi_result_if.source out_o
);

  phase_e phase_q, phase_d;

  logic [RHO_W-1:0]          rho_q;
  logic [DT_W-1:0]           dt_q;
  logic                      rk_q;
  logic signed [STATE_W-1:0] start_q [3];
  logic signed [STATE_W-1:0] pos_q [3];
  logic signed [STATE_W-1:0] pt_q [3];
  logic signed [STATE_W-1:0] dk_q [3];
  logic signed [KS_W-1:0]    ks_q [3];
  logic [1:0]                comp_q;
  logic [1:0]                stage_q;
  logic [CNT_W-1:0]          count_q;
  logic                      clip_q;
  logic                      reload_q;
  logic signed [PROD_W-1:0]  mul_q, hold_q, prod;
  logic signed [OP_W-1:0]    mul_a, mul_b, dt_op;
  logic signed [EXT_W-1:0]   sat_in, diff;
  sat_t                      sat_r;
  logic                      clip_set;
  logic                      in_ready, slot_free, div_start, div_done;
  logic signed [QUOT_W-1:0]  div_quot;

  logic                      out_valid_q;
  logic signed [STATE_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [CNT_W-1:0]          out_idx_q;
  logic                      out_sat_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign dt_op       = $signed({{(OP_W-DT_W){1'b0}}, dt_q});
  assign prod        = mul_a * mul_b;

  lsi_div6 u_div6 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_q[PROD_W-1:DT_W]),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequence derivative, move and final update steps
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: if (in_i.valid) phase_d = in_i.reload ? PH_FIN : PH_EV0;
      PH_EV0:  phase_d = PH_EV1;
      PH_EV1:  phase_d = PH_EV2;
      PH_EV2:  phase_d = PH_EV3;
      PH_EV3:  phase_d = rk_q ? PH_ACC : PH_MVM;
      PH_ACC:  phase_d = (stage_q == 2'd3) ? PH_FM : PH_MVM;
      PH_MVM:  phase_d = PH_MVA;
      PH_MVA:  begin
        if (comp_q == 2'd2) phase_d = rk_q ? PH_EV0 : PH_FIN;
        else                phase_d = PH_MVM;
      end
      PH_FM:   phase_d = PH_FDS;
      PH_FDS:  phase_d = PH_FDW;
      PH_FDW:  if (div_done) phase_d = PH_FA;
      PH_FA:   phase_d = (comp_q == 2'd2) ? PH_FIN : PH_FM;
      PH_FIN:  if (slot_free) phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  // Handshakes, multiplier operands and saturator input
  always_comb begin
    in_ready  = (phase_q == PH_IDLE);
    slot_free = !out_valid_q || out_o.ready;
    div_start = (phase_q == PH_FDS);
    mul_a     = OP_W'(pt_q[0]);
    mul_b     = OP_W'(pt_q[1]);
    sat_in    = '0;
    diff      = EXT_W'(pt_q[1]) - EXT_W'(pt_q[0]);
    clip_set  = 1'b0;
    unique case (phase_q)
      PH_EV0: begin
        mul_b    = OP_W'($signed({1'b0, rho_q})) - OP_W'(pt_q[2]);
        sat_in   = (diff <<< 3) + (diff <<< 1);
        clip_set = 1'b1;
      end
      PH_EV1: begin
        sat_in   = EXT_W'(mul_q >>> FRAC_W) - EXT_W'(pt_q[1]);
        clip_set = 1'b1;
      end
      PH_EV2: begin
        mul_a = OP_W'(BETA_Q);
        mul_b = OP_W'(pt_q[2]);
      end
      PH_EV3: begin
        sat_in   = (EXT_W'(hold_q) - EXT_W'(mul_q)) >>> FRAC_W;
        clip_set = 1'b1;
      end
      PH_MVM: begin
        mul_a = OP_W'(dk_q[comp_q]);
        mul_b = dt_op;
      end
      PH_MVA: begin
        if (rk_q && stage_q < 2'd2) sat_in = EXT_W'(mul_q >>> (DT_W + 1));
        else                        sat_in = EXT_W'(mul_q >>> DT_W);
        sat_in   = sat_in + EXT_W'(pos_q[comp_q]);
        clip_set = 1'b1;
      end
      PH_FM: begin
        mul_a = OP_W'(ks_q[comp_q]);
        mul_b = dt_op;
      end
      PH_FA: begin
        sat_in   = EXT_W'(pos_q[comp_q]) + EXT_W'(div_quot);
        clip_set = 1'b1;
      end
      default: ;
    endcase
    sat_r    = sat_state(sat_in);
    clip_set = clip_set && sat_r.clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      rho_q       <= RHO_RST;
      dt_q        <= DT_RST;
      rk_q        <= 1'b0;
      start_q     <= '{ONE_Q, ONE_Q, ONE_Q};
      pos_q       <= '{ONE_Q, ONE_Q, ONE_Q};
      count_q     <= '0;
      comp_q      <= '0;
      stage_q     <= '0;
      clip_q      <= 1'b0;
      reload_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mul_q   <= prod;

      // Take configuration writes
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          CFG_RHO: rho_q      <= cfg_i.data[RHO_W-1:0];
          CFG_DT:  dt_q       <= cfg_i.data[DT_W-1:0];
          CFG_RK:  rk_q       <= cfg_i.data[0];
          CFG_SX:  start_q[0] <= $signed(cfg_i.data[STATE_W-1:0]);
          CFG_SY:  start_q[1] <= $signed(cfg_i.data[STATE_W-1:0]);
          CFG_SZ:  start_q[2] <= $signed(cfg_i.data[STATE_W-1:0]);
          default: ;
        endcase
      end

      // Latch the tick and seed the working point
      if (in_i.valid && in_ready) begin
        reload_q <= in_i.reload;
        clip_q   <= 1'b0;
        stage_q  <= '0;
        comp_q   <= '0;
        pt_q     <= in_i.reload ? start_q : pos_q;
      end

      unique case (phase_q)
        PH_EV0: dk_q[0] <= sat_r.val;
        PH_EV1: dk_q[1] <= sat_r.val;
        PH_EV2: hold_q  <= mul_q;
        PH_EV3: dk_q[2] <= sat_r.val;
        PH_ACC: begin
          for (int i = 0; i < 3; i++) begin
            if (stage_q == 2'd0)      ks_q[i] <= KS_W'(dk_q[i]);
            else if (stage_q == 2'd3) ks_q[i] <= ks_q[i] + KS_W'(dk_q[i]);
            else                      ks_q[i] <= ks_q[i] + (KS_W'(dk_q[i]) <<< 1);
          end
        end
        PH_MVA: begin
          pt_q[comp_q] <= sat_r.val;
          if (comp_q == 2'd2) begin
            comp_q  <= '0;
            stage_q <= stage_q + 2'd1;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        PH_FA: begin
          pt_q[comp_q] <= sat_r.val;
          comp_q       <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
        end
        default: ;
      endcase

      if (clip_set) clip_q <= 1'b1;

      // Load a finished result, else drop a taken one
      if (phase_q == PH_FIN && slot_free) begin
        pos_q       <= pt_q;
        count_q     <= reload_q ? '0 : count_q + CNT_W'(1);
        out_valid_q <= 1'b1;
        out_x_q     <= pt_q[0];
        out_y_q     <= pt_q[1];
        out_z_q     <= pt_q[2];
        out_idx_q   <= reload_q ? '0 : count_q + CNT_W'(1);
        out_sat_q   <= clip_q;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_x      = out_x_q;
  assign out_o.out_y      = out_y_q;
  assign out_o.out_z      = out_z_q;
  assign out_o.step_index = out_idx_q;
  assign out_o.saturated  = out_sat_q;

endmodule

@@ design/lsi_div6.sv @@
// Digit-serial floor division by six, six dividend bits per cycle.
module lsi_div6 import lsi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIVD_W-1:0] dividend_i,
  output logic                     done_o,
  output logic signed [QUOT_W-1:0] quotient_o
);

  logic [DIV_SH_W-1:0] sh_q, sh_d;
  logic [2:0]          rem_q, rem_d;
  logic [2:0]          cnt_q;
  logic                neg_q;
  logic                done_q;
  logic [DIVD_W-1:0]   mag;

  assign mag = dividend_i[DIVD_W-1] ? DIVD_W'(-dividend_i) : DIVD_W'(dividend_i);

  // One digit of long division: shift in six bits, subtract six where it fits
  always_comb begin
    logic [3:0]           cur;
    logic [2:0]           r;
    logic [DIV_DIGIT-1:0] qb;
    r  = rem_q;
    qb = '0;
    for (int j = 0; j < DIV_DIGIT; j++) begin
      cur = {r, sh_q[DIV_SH_W-1-j]};
      if (cur >= 4'd6) begin
        r             = 3'(cur - 4'd6);
        qb[DIV_DIGIT-1-j] = 1'b1;
      end else begin
        r = cur[2:0];
      end
    end
    rem_d = r;
    sh_d  = {sh_q[DIV_SH_W-DIV_DIGIT-1:0], qb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      rem_q  <= '0;
      neg_q  <= 1'b0;
      sh_q   <= '0;
    end else if (start_i) begin
      sh_q   <= DIV_SH_W'(mag);
      rem_q  <= '0;
      neg_q  <= dividend_i[DIVD_W-1];
      cnt_q  <= 3'(DIV_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      sh_q   <= sh_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_q - 3'd1;
      done_q <= (cnt_q == 3'd1);
    end else begin
      done_q <= 1'b0;
    end
  end

  // Round toward minus infinity for negative dividends
  assign quotient_o = neg_q ? (-$signed({1'b0, sh_q}) - QUOT_W'(rem_q != '0))
                            : $signed({1'b0, sh_q});
  assign done_o = done_q;

endmodule

@@ design/lsi_checker.sv @@
// Port-level checks on the Lorenz integrator, bound to the top level.
module lsi_checker import lsi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_reload,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CNT_W-1:0] out_step_index,
  input logic             out_saturated
);

  // The block goes busy once a tick beat is taken
  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a tick beat");

  // A reload into an empty output is offered with index zero and no clip once PH_FIN loads it
  a_reload_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_reload && !out_valid
    |=> ##1 (out_valid && out_step_index == '0 && !out_saturated))
    else $error("reload result missing or wrong");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_step_index)
    && $stable(out_saturated))
    else $error("result beat changed while stalled");

endmodule

bind lorenz_system_integrator_core lsi_checker u_lsi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .in_reload      (in_i.reload),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .out_step_index (out_o.step_index),
  .out_saturated  (out_o.saturated)
);

@@ dv/tb_lorenz_system_integrator_core.sv @@
// Testbench for the Lorenz integrator core: random ticks checked against a local predictor.
module tb_lorenz_system_integrator_core;
  import lsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [STATE_W-1:0] x;
    logic signed [STATE_W-1:0] y;
    logic signed [STATE_W-1:0] z;
    logic [CNT_W-1:0]          idx;
    logic                      sat;
  } lorenz_res_t;

  localparam longint LIM_HI = 64'sd2147483647;
  localparam longint LIM_LO = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lsi_cfg_if    cfg_ch();
  lsi_tick_if   tick_ch();
  lsi_result_if res_ch();

  lorenz_system_integrator_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .in_i  (tick_ch.sink),
    .out_o (res_ch.source)
  );

  // Predictor copy of registers and state
  logic [RHO_W-1:0]          p_rho;
  logic [DT_W-1:0]           p_dt;
  logic                      p_rk;
  logic signed [STATE_W-1:0] p_sx, p_sy, p_sz;
  logic signed [STATE_W-1:0] p_x, p_y, p_z;
  logic [CNT_W-1:0]          p_cnt;
  logic                      p_clip;

  logic        tick_q[$];
  lorenz_res_t state_expected_q[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          n_fail;
  bit          cfg_busy;
  bit          tick_taken;

  // Clamp an exact value to the state range and note any clip
  function automatic logic signed [STATE_W-1:0] clamp(input logic signed [127:0] v);
    if (v > 128'(LIM_HI)) begin
      p_clip = 1'b1;
      return STATE_W'(LIM_HI);
    end
    if (v < 128'(LIM_LO)) begin
      p_clip = 1'b1;
      return STATE_W'(LIM_LO);
    end
    return STATE_W'(v);
  endfunction

  // Lorenz derivative at point s
  task automatic lorenz_deriv(input logic signed [STATE_W-1:0] s[3],
                              output logic signed [STATE_W-1:0] d[3]);
    logic signed [127:0] sx, sy, sz, rho, beta, t;
    sx = s[0];
    sy = s[1];
    sz = s[2];
    rho = {98'd0, p_rho};
    beta = BETA_Q;
    d[0] = clamp(sy * 10 - sx * 10);
    t = (sx * rho - sx * sz) >>> FRAC_W;
    d[1] = clamp(t - sy);
    d[2] = clamp((sx * sy - beta * sz) >>> FRAC_W);
  endtask

  function automatic logic signed [127:0] dt_prod(input logic signed [STATE_W-1:0] k);
    logic signed [127:0] a, b;
    a = k;
    b = {96'd0, p_dt};
    return a * b;
  endfunction

  // Step from base along k scaled by dt / 2^sh
  task automatic lorenz_move(input logic signed [STATE_W-1:0] base[3],
                             input logic signed [STATE_W-1:0] k[3], input int sh,
                             output logic signed [STATE_W-1:0] o[3]);
    logic signed [127:0] b;
    for (int i = 0; i < 3; i++) begin
      b = base[i];
      o[i] = clamp(b + (dt_prod(k[i]) >>> sh));
    end
  endtask

  // Work out the result of one tick and advance the predictor
  task automatic lorenz_predict(input logic reload);
    logic signed [STATE_W-1:0] s[3], k1[3], k2[3], k3[3], k4[3], t[3];
    logic signed [127:0] sum, q, b;
    lorenz_res_t r;
    p_clip = 1'b0;
    if (reload) begin
      p_x = p_sx;
      p_y = p_sy;
      p_z = p_sz;
      p_cnt = '0;
    end else begin
      s[0] = p_x;
      s[1] = p_y;
      s[2] = p_z;
      lorenz_deriv(s, k1);
      if (p_rk) begin
        lorenz_move(s, k1, 33, t);
        lorenz_deriv(t, k2);
        lorenz_move(s, k2, 33, t);
        lorenz_deriv(t, k3);
        lorenz_move(s, k3, 32, t);
        lorenz_deriv(t, k4);
        for (int i = 0; i < 3; i++) begin
          sum = dt_prod(k1[i]) + dt_prod(k4[i]) + 2 * dt_prod(k2[i]) + 2 * dt_prod(k3[i]);
          sum = sum >>> 32;
          // floor division by six
          q = sum / 6;
          if (sum < 0 && q * 6 != sum) q = q - 1;
          b = s[i];
          t[i] = clamp(b + q);
        end
      end else begin
        lorenz_move(s, k1, 32, t);
      end
      p_x = t[0];
      p_y = t[1];
      p_z = t[2];
      p_cnt = p_cnt + 1'b1;
    end
    r.x = p_x;
    r.y = p_y;
    r.z = p_z;
    r.idx = p_cnt;
    r.sat = p_clip;
    state_expected_q.push_back(r);
  endtask

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Tick driver: present queued beats at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      tick_ch.valid <= 1'b0;
      tick_ch.reload <= 1'b0;
    end else if (!tick_ch.valid || tick_taken) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_ch.valid <= 1'b1;
        tick_ch.reload <= tick_q.pop_front();
      end else begin
        tick_ch.valid <= 1'b0;
        tick_ch.reload <= 1'($urandom_range(1));
      end
    end
  end

  // Predict on each accepted tick
  always @(posedge clk_i) begin
    tick_taken = rst_ni && tick_ch.valid && tick_ch.ready;
    if (tick_taken) lorenz_predict(tick_ch.reload);
  end

  // Result stalls
  always @(negedge clk_i) begin
    res_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    lorenz_res_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (state_expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        e = state_expected_q.pop_front();
        if (res_ch.out_x !== e.x) begin
          $error("out_x expected %0d got %0d", e.x, res_ch.out_x);
          n_fail++;
        end
        if (res_ch.out_y !== e.y) begin
          $error("out_y expected %0d got %0d", e.y, res_ch.out_y);
          n_fail++;
        end
        if (res_ch.out_z !== e.z) begin
          $error("out_z expected %0d got %0d", e.z, res_ch.out_z);
          n_fail++;
        end
        if (res_ch.step_index !== e.idx) begin
          $error("step_index expected %0d got %0d", e.idx, res_ch.step_index);
          n_fail++;
        end
        if (res_ch.saturated !== e.sat) begin
          $error("saturated expected %0d got %0d", e.sat, res_ch.saturated);
          n_fail++;
        end
      end
    end
  end

  // Write one register while the block is idle
  task automatic reg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_RHO: p_rho = val[RHO_W-1:0];
      CFG_DT:  p_dt = val;
      CFG_RK:  p_rk = val[0];
      CFG_SX:  p_sx = val;
      CFG_SY:  p_sy = val;
      CFG_SZ:  p_sz = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait for all results, then let the block settle
  task automatic drain();
    while (tick_q.size() > 0 || tick_ch.valid || state_expected_q.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Load one phase of settings; mostly tame values, sometimes extremes
  task automatic phase_setup(input int ph);
    logic [31:0] r;
    reg_write(CFG_RK, 32'(ph[0]));
    case (ph % 4)
      0: reg_write(CFG_RHO, 32'd117440512);
      1: reg_write(CFG_RHO, $urandom_range(838860800));
      2: reg_write(CFG_RHO, 32'hFFFF_FFFF);
      default: reg_write(CFG_RHO, 32'd0);
    endcase
    r = (ph % 5 == 4) ? $urandom() : $urandom_range(200000000);
    reg_write(CFG_DT, r);
    if (ph % 6 == 5) begin
      reg_write(CFG_SX, $urandom());
      reg_write(CFG_SY, $urandom());
      reg_write(CFG_SZ, $urandom());
    end else begin
      reg_write(CFG_SX, $signed($urandom_range(80)) - 40 <<< FRAC_W);
      reg_write(CFG_SY, ($signed($urandom_range(80)) - 40) <<< FRAC_W | $urandom_range(4194303));
      reg_write(CFG_SZ, $signed($urandom_range(50)) <<< FRAC_W);
    end
  endtask

  initial begin
    p_rho = RHO_RST;
    p_dt = DT_RST;
    p_rk = 1'b0;
    p_sx = ONE_Q;
    p_sy = ONE_Q;
    p_sz = ONE_Q;
    p_x = ONE_Q;
    p_y = ONE_Q;
    p_z = ONE_Q;
    p_cnt = '0;
    n_fail = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.reload = 1'b0;
    res_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset defaults, Euler then RK4, extremes
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    drain();
    reg_write(CFG_RK, 32'd1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b0);
    drain();
    reg_write(CFG_SX, 32'h7FFF_FFFF);
    reg_write(CFG_SY, 32'h8000_0000);
    reg_write(CFG_SZ, 32'h7FFF_FFFF);
    reg_write(CFG_DT, 32'hFFFF_FFFF);
    reg_write(CFG_RHO, 32'hFFFF_FFFF);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b0);
    drain();
    reg_write(CFG_RK, 32'd0);
    reg_write(CFG_SX, 32'h8000_0000);
    reg_write(CFG_SY, 32'h7FFF_FFFF);
    reg_write(CFG_SZ, 32'h8000_0000);
    reg_write(CFG_DT, 32'd0);
    reg_write(CFG_RHO, 32'd0);
    for (int i = 0; i < 3; i++) tick_q.push_back(i == 0);
    drain();

    // Random phases over the idling profiles
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      phase_setup(ph);
      tick_q.push_back(1'b1);
      for (int i = 0; i < 50; i++) tick_q.push_back($urandom_range(15) == 0);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (n_fail == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lsi_pkg.sv
design/lsi_tick_if.sv
design/lsi_result_if.sv
design/lsi_cfg_if.sv
design/lsi_div6.sv
design/lorenz_system_integrator_core.sv
design/lsi_checker.sv
dv/tb_lorenz_system_integrator_core.sv
